### sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// types and constants shared by the triangle face normal unit
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int OUT_WIDTH   = 16;
  localparam int SCALE_BITS  = 30;
  localparam int ROOT_BITS   = 16;
  localparam int SUM_WIDTH   = 2 * SCALE_BITS + 2;
  localparam int REM_WIDTH   = 3 * SCALE_BITS + 6;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by_coord;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic                          last_triangle;
  } tfn_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] nx;
    logic signed [OUT_WIDTH-1:0] ny;
    logic signed [OUT_WIDTH-1:0] nz;
    logic                        degenerate;
    logic                        last_normal;
  } tfn_out_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degenerate;
    logic       last;
  } tfn_tag_t;

  typedef struct packed {
    logic [REM_WIDTH-1:0] rem;
    logic [REM_WIDTH-1:0] prod;
    logic [ROOT_BITS-1:0] root;
  } tfn_lane_t;

endpackage

### sv/triangle_face_normal_unit.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// unit face normal of one triangle per word, signed Q1.14
// ----------------------------------------------------------------------------
// in_word carries the three vertices a, b, c (signed Q8.8) and a last mark.
// a word is taken when in_valid is high and in_stall is low; out_word is
// taken when out_valid is high and out_stall is low.
// the unit takes one word every cycle while in_stall is low and gives one
// word per input word, in order, through one stage for the edge vectors,
// one for the six products, one for the cross product, two to bring the
// largest component to 30 bits, one for the squares, one for their sum,
// sixteen for the bit-by-bit root search (one result bit per stage, three
// lanes side by side) and the output register.
// a zero cross product gives a zero vector with degenerate set.
// reset empties every stage; words in flight are dropped.
// while out_stall holds a waiting word, the whole pipeline freezes and
// in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tfn_pkg::tfn_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output tfn_pkg::tfn_out_t out_word
);
  import tfn_pkg::*;

  localparam int ESH = (COORD_WIDTH > SCALE_BITS) ? COORD_WIDTH - SCALE_BITS : 0;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int EW  = DW - ESH;
  localparam int CMW = 2 * EW;
  localparam int MW  = (CMW > SCALE_BITS) ? CMW : SCALE_BITS;
  localparam int LW  = $clog2(MW + 1);

  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // stage 1: edge vectors
  logic signed [EW-1:0] e_r [3];
  logic signed [EW-1:0] f_r [3];
  logic signed [EW-1:0] e_nxt [3];
  logic signed [EW-1:0] f_nxt [3];
  logic                 v1_r;
  logic                 last1_r;
  logic signed [DW-1:0] va [3];
  logic signed [DW-1:0] vb [3];
  logic signed [DW-1:0] vc [3];
  logic signed [DW-1:0] de [3];
  logic signed [DW-1:0] df [3];

  always_comb begin
    va[0] = DW'(in_word.ax);
    va[1] = DW'(in_word.ay);
    va[2] = DW'(in_word.az);
    vb[0] = DW'(in_word.bx);
    vb[1] = DW'(in_word.by_coord);
    vb[2] = DW'(in_word.bz);
    vc[0] = DW'(in_word.cx);
    vc[1] = DW'(in_word.cy);
    vc[2] = DW'(in_word.cz);
    for (int i = 0; i < 3; i++) begin
      de[i]    = vb[i] - va[i];
      df[i]    = vc[i] - va[i];
      e_nxt[i] = EW'(de[i] >>> ESH);
      f_nxt[i] = EW'(df[i] >>> ESH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e_r     <= e_nxt;
      f_r     <= f_nxt;
      last1_r <= in_word.last_triangle;
    end
  end

  // stage 2: products
  logic signed [CMW-1:0] pa_r [3];
  logic signed [CMW-1:0] pb_r [3];
  logic signed [CMW-1:0] pa_nxt [3];
  logic signed [CMW-1:0] pb_nxt [3];
  logic                  v2_r;
  logic                  last2_r;

  always_comb begin
    pa_nxt[0] = CMW'(e_r[1]) * CMW'(f_r[2]);
    pb_nxt[0] = CMW'(e_r[2]) * CMW'(f_r[1]);
    pa_nxt[1] = CMW'(e_r[2]) * CMW'(f_r[0]);
    pb_nxt[1] = CMW'(e_r[0]) * CMW'(f_r[2]);
    pa_nxt[2] = CMW'(e_r[0]) * CMW'(f_r[1]);
    pb_nxt[2] = CMW'(e_r[1]) * CMW'(f_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (advance) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      last2_r <= last1_r;
    end
  end

  // stage 3: cross product magnitudes and signs
  logic [CMW-1:0]        mag3_r [3];
  logic [CMW-1:0]        mag3_nxt [3];
  logic signed [CMW:0]   cr [3];
  tfn_tag_t              tag3_r;
  tfn_tag_t              tag3_nxt;
  logic                  v3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i]           = (CMW + 1)'(pa_r[i]) - (CMW + 1)'(pb_r[i]);
      tag3_nxt.neg[i] = cr[i][CMW];
      mag3_nxt[i]     = cr[i][CMW] ? CMW'(-cr[i]) : CMW'(cr[i]);
    end
    tag3_nxt.degenerate = (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
    tag3_nxt.last       = last2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (advance) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mag3_r <= mag3_nxt;
      tag3_r <= tag3_nxt;
    end
  end

  // stage 4: shift amount from the widest magnitude
  logic [MW-1:0] mag4_r [3];
  logic [LW-1:0] sh4_r;
  logic [LW-1:0] sh4_nxt;
  logic [LW-1:0] len;
  logic [MW-1:0] mor;
  tfn_tag_t      tag4_r;
  logic          v4_r;

  always_comb begin
    mor = MW'(mag3_r[0] | mag3_r[1] | mag3_r[2]);
    len = '0;
    for (int i = 0; i < MW; i++) begin
      if (mor[i]) begin
        len = LW'(i + 1);
      end
    end
    sh4_nxt = (len > LW'(SCALE_BITS)) ? LW'(len - LW'(SCALE_BITS)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (advance) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        mag4_r[i] <= MW'(mag3_r[i]);
      end
      sh4_r  <= sh4_nxt;
      tag4_r <= tag3_r;
    end
  end

  // stage 5: reduce to 30 bits
  logic [SCALE_BITS-1:0] u5_r [3];
  tfn_tag_t              tag5_r;
  logic                  v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (advance) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        u5_r[i] <= SCALE_BITS'(mag4_r[i] >> sh4_r);
      end
      tag5_r <= tag4_r;
    end
  end

  // stage 6: squares
  logic [2*SCALE_BITS-1:0] sq6_r [3];
  tfn_tag_t                tag6_r;
  logic                    v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (advance) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= (2 * SCALE_BITS)'(u5_r[i]) * (2 * SCALE_BITS)'(u5_r[i]);
      end
      tag6_r <= tag5_r;
    end
  end

  // stage 7 and root search: largest k with k*k*sum <= u*u*2^30
  logic [SUM_WIDTH-1:0] sum_r  [ROOT_BITS+1];
  tfn_lane_t            lane_r [ROOT_BITS+1][3];
  tfn_tag_t             tag_r  [ROOT_BITS+1];
  logic                 vs_r   [ROOT_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else if (advance) begin
      vs_r[0] <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum_r[0] <= SUM_WIDTH'(sq6_r[0]) + SUM_WIDTH'(sq6_r[1]) + SUM_WIDTH'(sq6_r[2]);
      for (int i = 0; i < 3; i++) begin
        lane_r[0][i].rem  <= REM_WIDTH'(sq6_r[i]) << SCALE_BITS;
        lane_r[0][i].prod <= '0;
        lane_r[0][i].root <= '0;
      end
      tag_r[0] <= tag6_r;
    end
  end

  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_step
    localparam int J = ROOT_BITS - 1 - s;
    logic [REM_WIDTH-1:0] trial [3];
    tfn_lane_t            lane_nxt [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = (lane_r[s][i].prod << (J + 1)) +
                   (REM_WIDTH'(sum_r[s]) << (2 * J));
        lane_nxt[i] = lane_r[s][i];
        if (trial[i] <= lane_r[s][i].rem) begin
          lane_nxt[i].rem  = lane_r[s][i].rem - trial[i];
          lane_nxt[i].prod = lane_r[s][i].prod + (REM_WIDTH'(sum_r[s]) << J);
          lane_nxt[i].root = lane_r[s][i].root | (ROOT_BITS'(1) << J);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[s+1] <= 1'b0;
      end else if (advance) begin
        vs_r[s+1] <= vs_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        lane_r[s+1] <= lane_nxt;
        sum_r[s+1]  <= sum_r[s];
        tag_r[s+1]  <= tag_r[s];
      end
    end
  end

  // output register: round half up on the doubled root, then sign
  logic [ROOT_BITS:0]    qw [3];
  logic [OUT_WIDTH-1:0]  q [3];
  logic [OUT_WIDTH-1:0]  n_nxt [3];
  tfn_tag_t              tag_f;
  tfn_out_t              out_r;
  tfn_out_t              out_nxt;
  logic                  out_valid_r;

  always_comb begin
    tag_f = tag_r[ROOT_BITS];
    for (int i = 0; i < 3; i++) begin
      qw[i] = (ROOT_BITS + 1)'(lane_r[ROOT_BITS][i].root) + (ROOT_BITS + 1)'(1);
      q[i]  = OUT_WIDTH'(qw[i][ROOT_BITS:1]);
      if (tag_f.degenerate) begin
        n_nxt[i] = '0;
      end else if (tag_f.neg[i]) begin
        n_nxt[i] = -q[i];
      end else begin
        n_nxt[i] = q[i];
      end
    end
    out_nxt.nx          = n_nxt[0];
    out_nxt.ny          = n_nxt[1];
    out_nxt.nz          = n_nxt[2];
    out_nxt.degenerate  = tag_f.degenerate;
    out_nxt.last_normal = tag_f.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vs_r[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
